### design/rpv_pkg.sv
// Shared package of the pairwise repulsion velocity unit.
// Holds field widths, unit sizes, the register map, the state type and helpers.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package rpv_pkg;

   localparam int POS_W    = 24;
   localparam int RAD_W    = 16;
   localparam int STIFF_W  = 16;
   localparam int VEL_W    = 32;
   localparam int REST_W   = RAD_W + 1;
   localparam int MAG_W    = 17;
   localparam int SQ_W     = 2 * MAG_W + 1;
   localparam int ROOT_W   = 18;
   localparam int MUL_A_W  = 34;
   localparam int MUL_B_W  = 17;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W  = 50;
   localparam int DIV_D_W  = 25;
   localparam int Q_W      = 33;
   localparam int PUSH_W   = 25;
   localparam int ADDR_W   = 3;

   localparam logic [STIFF_W-1:0] STIFF_RESET   = 16'd1280;
   localparam logic               REG_STIFFNESS = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQR,
      ST_ROOT,
      ST_KOV,
      ST_KOV2,
      ST_DIVQ,
      ST_MULX,
      ST_DIVX,
      ST_MULY,
      ST_DIVY,
      ST_FIN
   } state_type;

   // Adds or subtracts a push magnitude and clamps to the signed 32-bit range.
   function automatic logic [VEL_W-1:0] sat_push(input logic [VEL_W-1:0] acc,
                                                 input logic [PUSH_W-1:0] mag,
                                                 input logic sub);
      logic [VEL_W:0] a_ext;
      logic [VEL_W:0] m_ext;
      logic [VEL_W:0] sum;
      logic [VEL_W-1:0] res;
      a_ext = {acc[VEL_W-1], acc};
      m_ext = {{(VEL_W + 1 - PUSH_W){1'b0}}, mag};
      sum = sub ? (a_ext - m_ext) : (a_ext + m_ext);
      if (sum[VEL_W] != sum[VEL_W-1]) begin
         res = sum[VEL_W] ? {1'b1, {(VEL_W - 1){1'b0}}} : {1'b0, {(VEL_W - 1){1'b1}}};
      end else begin
         res = sum[VEL_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### design/pairwise_repulsion_velocity_unit.sv
// Top level of the pairwise repulsion velocity unit: control sequencer,
// accumulators, result register and register port. Uses rpv_pkg and the
// serial multiplier, divider and square root units.
`default_nettype none
// The unit takes the neighbours of one cell, one transfer per neighbour, and
// sums the velocity that quadratic overlap repulsion gives the cell. A
// neighbour that is the cell itself, that sits on the cell centre, or that is
// more than 17 bits away on either axis adds nothing and goes straight to the
// finish step. Any other neighbour first goes through three squares on one
// shared bit-serial multiplier; if its squared centre distance is at least
// the square of the summed radii it adds nothing. An overlapping neighbour
// then also goes through a bit-serial square root, two products for stiffness
// times the squared overlap, a division by the rest length on one restoring
// divider, and one product and one division for each axis. Only one neighbour
// is in flight; the next is taken once the previous one is summed. On the
// neighbour marked last the two sums are moved, saturated to 32 bits, into the
// result register and cleared; that result waits there while the next cell's
// neighbours are already taken, and the unit only holds on the last neighbour
// of the following cell if the earlier result has not yet been taken. The
// stiffness register sits at byte address 0 and resets to 5.0 in Q8.8.
module pairwise_repulsion_velocity_unit
   import rpv_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // neighbour channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [POS_W-1:0]    req_cell_x,
   input  wire logic signed [POS_W-1:0]    req_cell_y,
   input  wire logic        [RAD_W-1:0]    req_cell_radius,
   input  wire logic signed [POS_W-1:0]    req_nbr_x,
   input  wire logic signed [POS_W-1:0]    req_nbr_y,
   input  wire logic        [RAD_W-1:0]    req_nbr_radius,
   input  wire logic                       req_nbr_is_self,
   input  wire logic                       req_last,
   // result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [VEL_W-1:0]         rsp_vel_x,
   output logic signed [VEL_W-1:0]         rsp_vel_y,
   // register port
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [ADDR_W-1:0]          paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   state_type state_ff, state_in;

   logic [STIFF_W-1:0] stiff_ff;
   logic [MAG_W-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic               negx_ff, negx_in, negy_ff, negy_in;
   logic [REST_W-1:0]  rest_ff, rest_in;
   logic               last_ff, last_in;
   logic [SQ_W-1:0]    s_ff, s_in;
   logic [REST_W-1:0]  d_ff, d_in;
   logic [REST_W-1:0]  ov_ff, ov_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [VEL_W-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VEL_W-1:0]   vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;

   logic signed [POS_W:0] dx, dy;
   logic [POS_W:0]        adx, ady;
   logic                  skip;
   logic                  req_take;
   logic                  cfg_write;

   logic                       mul_start, mul_done;
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [MUL_P_W-1:0]         mul_p;
   logic                       div_start, div_done;
   logic [DIV_N_W-1:0]         div_n;
   logic [DIV_D_W-1:0]         div_d;
   logic [DIV_N_W-1:0]         div_q;
   logic                       sqrt_start, sqrt_done;
   logic [2*ROOT_W-1:0]        sqrt_rad;
   logic [ROOT_W-1:0]          sqrt_root;

   rpv_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   rpv_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_n), .denom(div_d),
      .done(div_done), .quotient(div_q)
   );

   rpv_sqrt #(.R_W(ROOT_W)) u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sqrt_rad),
      .done(sqrt_done), .root(sqrt_root)
   );

   // Register port: always ready, one register at index zero.
   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_STIFFNESS) ? {16'd0, stiff_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (cfg_write && paddr[2] == REG_STIFFNESS) begin
         stiff_ff <= pwdata[STIFF_W-1:0];
      end
   end

   // Offsets from the cell to the neighbour and their magnitudes. A magnitude
   // above 17 bits already puts the pair out of reach, since the squared rest
   // length stays below 2^34.
   assign dx = {req_nbr_x[POS_W-1], req_nbr_x} - {req_cell_x[POS_W-1], req_cell_x};
   assign dy = {req_nbr_y[POS_W-1], req_nbr_y} - {req_cell_y[POS_W-1], req_cell_y};
   assign adx = dx[POS_W] ? (POS_W + 1)'(0) - dx : dx;
   assign ady = dy[POS_W] ? (POS_W + 1)'(0) - dy : dy;
   assign skip = req_nbr_is_self || (dx == '0 && dy == '0) ||
                 (adx[POS_W:MAG_W] != '0) || (ady[POS_W:MAG_W] != '0);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      negx_in = negx_ff;
      negy_in = negy_ff;
      rest_in = rest_ff;
      last_in = last_ff;
      s_in = s_ff;
      d_in = d_ff;
      ov_in = ov_ff;
      q_in = q_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      mul_start = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_n = mul_p[DIV_N_W-1:0];
      div_d = '0;
      sqrt_start = 1'b0;
      sqrt_rad = {1'b0, s_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ax_in = adx[MAG_W-1:0];
               ay_in = ady[MAG_W-1:0];
               negx_in = dx[POS_W];
               negy_in = dy[POS_W];
               rest_in = {1'b0, req_cell_radius} + {1'b0, req_nbr_radius};
               last_in = req_last;
               if (skip) begin
                  state_in = ST_FIN;
               end else begin
                  mul_start = 1'b1;
                  mul_a = MUL_A_W'(adx[MAG_W-1:0]);
                  mul_b = adx[MAG_W-1:0];
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            if (mul_done) begin
               s_in = mul_p[SQ_W-1:0];
               mul_start = 1'b1;
               mul_a = MUL_A_W'(ay_ff);
               mul_b = ay_ff;
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            if (mul_done) begin
               s_in = s_ff + mul_p[SQ_W-1:0];
               mul_start = 1'b1;
               mul_a = MUL_A_W'(rest_ff);
               mul_b = rest_ff;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            // Exact overlap test: squared distance below squared rest length.
            if (mul_done) begin
               if (s_ff < mul_p[SQ_W-1:0]) begin
                  sqrt_start = 1'b1;
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               d_in = sqrt_root[REST_W-1:0];
               ov_in = rest_ff - sqrt_root[REST_W-1:0];
               mul_start = 1'b1;
               mul_a = MUL_A_W'(stiff_ff);
               mul_b = rest_ff - sqrt_root[REST_W-1:0];
               state_in = ST_KOV;
            end
         end
         ST_KOV: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a = mul_p[MUL_A_W-1:0];
               mul_b = ov_ff;
               state_in = ST_KOV2;
            end
         end
         ST_KOV2: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_d = DIV_D_W'(rest_ff);
               state_in = ST_DIVQ;
            end
         end
         ST_DIVQ: begin
            if (div_done) begin
               q_in = div_q[Q_W-1:0];
               mul_start = 1'b1;
               mul_a = MUL_A_W'(div_q[Q_W-1:0]);
               mul_b = ax_ff;
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_d = {d_ff, 8'd0};
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            // The push points away from the neighbour.
            if (div_done) begin
               acc_x_in = sat_push(acc_x_ff, div_q[PUSH_W-1:0], !negx_ff);
               mul_start = 1'b1;
               mul_a = MUL_A_W'(q_ff);
               mul_b = ay_ff;
               state_in = ST_MULY;
            end
         end
         ST_MULY: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_d = {d_ff, 8'd0};
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               acc_y_in = sat_push(acc_y_ff, div_q[PUSH_W-1:0], !negy_ff);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               vel_x_in = acc_x_ff;
               vel_y_in = acc_y_ff;
               acc_x_in = '0;
               acc_y_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      rest_ff <= rest_in;
      last_ff <= last_in;
      s_ff <= s_in;
      d_ff <= d_in;
      ov_ff <= ov_in;
      q_ff <= q_in;
      vel_x_ff <= vel_x_in;
      vel_y_ff <= vel_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vel_x = vel_x_ff;
   assign rsp_vel_y = vel_y_ff;

`ifndef SYNTH
   // The multiplier and the divider are never finishing in the same cycle.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   // The root of an overlapping pair stays below its rest length.
   a_root_below_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && sqrt_done) |-> (sqrt_root < ROOT_W'(rest_ff)))
      else $error("distance not below rest length");

   // A new result only appears after a last neighbour has been finished.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN && last_ff))
      else $error("result raised outside the finish step");

   // Sums are cleared right after a result is loaded.
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && last_ff && (!rsp_valid_ff || !rsp_stall))
      |=> (acc_x_ff == '0 && acc_y_ff == '0))
      else $error("sums not cleared after result");
`endif

endmodule
`default_nettype wire

### design/rpv_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on rpv_pkg for default widths.
`default_nettype none
module rpv_mul
   import rpv_pkg::*;
#(
   parameter int A_W = MUL_A_W,
   parameter int B_W = MUL_B_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [A_W-1:0]     a,
   input  wire logic [B_W-1:0]     b,
   output logic                    done,
   output logic [A_W+B_W-1:0]      product
);
   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         prod_in = '0;
         cnt_in = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {prod_ff[P_W-2:0], 1'b0} +
                   (b_ff[B_W-1] ? {{B_W{1'b0}}, a_ff} : {P_W{1'b0}});
         b_in = {b_ff[B_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign product = prod_ff;
endmodule
`default_nettype wire

### design/rpv_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rpv_pkg for default widths.
`default_nettype none
module rpv_div
   import rpv_pkg::*;
#(
   parameter int N_W = DIV_N_W,
   parameter int D_W = DIV_D_W
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [N_W-1:0] numer,
   input  wire logic [D_W-1:0] denom,
   output logic                done,
   output logic [N_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[N_W-1]};
      diff = trial - {1'b0, den_ff};
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[D_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### design/rpv_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on rpv_pkg for the default root width.
`default_nettype none
module rpv_sqrt
   import rpv_pkg::*;
#(
   parameter int R_W = ROOT_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [2*R_W-1:0] radicand,
   output logic                  done,
   output logic [R_W-1:0]        root
);
   localparam int CNT_W = $clog2(R_W + 1);

   logic [2*R_W-1:0] rad_ff, rad_in;
   logic [R_W:0]     rem_ff, rem_in;
   logic [R_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [R_W+2:0]   part;
   logic [R_W+2:0]   trial;
   logic [R_W+2:0]   diff;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      part = {rem_ff, rad_ff[2*R_W-1:2*R_W-2]};
      trial = {1'b0, root_ff, 2'b01};
      diff = part - trial;
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = CNT_W'(R_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*R_W-3:0], 2'b00};
         if (part >= trial) begin
            rem_in = diff[R_W:0];
            root_in = {root_ff[R_W-2:0], 1'b1};
         end else begin
            rem_in = part[R_W:0];
            root_in = {root_ff[R_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire
